// ----- sv/line_keyword_command_matcher_top_assert.svh -----
// Assertion macros for the line keyword command matcher.
`ifndef LINE_KEYWORD_COMMAND_MATCHER_TOP_ASSERT_SVH
`define LINE_KEYWORD_COMMAND_MATCHER_TOP_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define LKCM_ASSERT_IMPL(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("lkcm assertion failed: same-cycle check");

// The condition holds in the cycle after the trigger.
`define LKCM_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("lkcm assertion failed: next-cycle check");

`endif

// ----- sv/lkcm_pkg.sv -----
// Package with keyword tables, byte codes and command codes for the matcher.
package lkcm_pkg;

    localparam int unsigned MAX_LINE_LEN_DEF = 64;

    localparam int unsigned KW_COUNT = 5;
    localparam int unsigned KW_MAXLEN = 8;
    localparam int unsigned KW_IDX_W = $clog2(KW_MAXLEN);
    localparam int unsigned KW_LEN_W = 4;

    localparam logic [7:0] BYTE_CR = 8'd13;
    localparam logic [7:0] BYTE_LF = 8'd10;
    localparam logic [KW_COUNT-1:0] FLAGS_ALL = '1;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_SHUTDOWN = 3'd1,
        CMD_RUN      = 3'd2,
        CMD_ECHO     = 3'd3,
        CMD_WATCHDOG = 3'd4,
        CMD_PEAK     = 3'd5
    } cmd_code_t;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
        '{"S", "H", "U", "T", "D", "O", "W", "N"},
        '{"R", "U", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"E", "C", "H", "O", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"W", "A", "T", "C", "H", "D", "O", "G"},
        '{"P", "E", "A", "K", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd8, 4'd3, 4'd4, 4'd8, 4'd4
    };

    localparam cmd_code_t KW_CODE [KW_COUNT] = '{
        CMD_SHUTDOWN, CMD_RUN, CMD_ECHO, CMD_WATCHDOG, CMD_PEAK
    };

endpackage

// ----- sv/line_keyword_command_matcher_top.sv -----
// Line keyword command matcher: one byte per item, command code per item.
// Each accepted byte is registered in stage 1; its command code is registered in the output register.
// Throughput: one item per cycle while out_ready does not stall the output, set by the length and flag update.
// Reset clears the line length, sets all keyword flags and empties both stages.
`include "line_keyword_command_matcher_top_assert.svh"

module line_keyword_command_matcher_top #(
    parameter int unsigned MAX_LINE_LEN = lkcm_pkg::MAX_LINE_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] command_code
);
    import lkcm_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_LINE_LEN);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE_LEN - 1);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [7:0]          s1_byte_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    cmd_code_t           command_code_reg;
    cmd_code_t           command_code_next;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic [KW_COUNT-1:0] flags_reg;
    logic [KW_COUNT-1:0] flags_next;

    logic in_fire;
    logic s1_fire;
    logic out_space;

    assign out_space = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && out_space;
    assign in_ready  = !s1_valid_reg || out_space;
    assign in_fire   = in_valid && in_ready;

    assign out_valid    = out_valid_reg;
    assign command_code = command_code_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        len_next          = len_reg;
        flags_next        = flags_reg;
        command_code_next = CMD_NONE;
        if (s1_byte_reg == BYTE_LF)
        begin
            for (int k = KW_COUNT - 1; k >= 0; k--)
            begin
                if (flags_reg[k] && len_reg == LEN_W'(KW_LEN[k]))
                begin
                    command_code_next = KW_CODE[k];
                end
            end
            len_next   = '0;
            flags_next = FLAGS_ALL;
        end
        else if (s1_byte_reg != BYTE_CR && len_reg < LEN_MAX)
        begin
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (!(len_reg < LEN_W'(KW_LEN[k]) &&
                      KW_TEXT[k][len_reg[KW_IDX_W-1:0]] == s1_byte_reg))
                begin
                    flags_next[k] = 1'b0;
                end
            end
            len_next = len_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            flags_reg     <= FLAGS_ALL;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                len_reg   <= len_next;
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (s1_fire)
        begin
            command_code_reg <= command_code_next;
        end
    end

    `LKCM_ASSERT_IMPL(a_len_bounded, clk, rst_n, 1'b1, len_reg <= LEN_MAX)
    `LKCM_ASSERT_NEXT(a_code_only_on_lf, clk, rst_n,
        s1_fire && s1_byte_reg != BYTE_LF, command_code_reg == CMD_NONE)
    `LKCM_ASSERT_NEXT(a_lf_clears_line, clk, rst_n,
        s1_fire && s1_byte_reg == BYTE_LF, len_reg == '0 && flags_reg == FLAGS_ALL)
    `LKCM_ASSERT_NEXT(a_cr_keeps_state, clk, rst_n,
        s1_fire && s1_byte_reg == BYTE_CR, $stable(len_reg) && $stable(flags_reg))

endmodule
